[hdl/sgi_pkg.sv]
// Shared types for the 2-D segment intersection pipeline.
// No dependencies; used by sgi_cross, sgi_div and the top level.
package sgi_pkg;

    // Per-stage control that travels alongside the data words.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } sgi_ctl_t;

endpackage

[hdl/segment_intersection_2d_unit.sv]
// Throughput: one segment pair per cycle unless out_ready stalls the pipeline;
// the quotient pipeline, one stage per bit of the edge magnitude, sets the
// depth, and every stage holds its own item.
// Reset clears only the valid and control fields of the stages; data registers are not reset.
// Depends on sgi_pkg, sgi_cross and sgi_div.
module segment_intersection_2d_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_BITS-1:0]   x1,
    input  logic signed [COORD_BITS-1:0]   y1,
    input  logic signed [COORD_BITS-1:0]   x2,
    input  logic signed [COORD_BITS-1:0]   y2,
    input  logic signed [COORD_BITS-1:0]   x3,
    input  logic signed [COORD_BITS-1:0]   y3,
    input  logic signed [COORD_BITS-1:0]   x4,
    input  logic signed [COORD_BITS-1:0]   y4,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic signed [COORD_BITS-1:0]   cross_x,
    output logic signed [COORD_BITS-1:0]   cross_y
);

    localparam int C  = COORD_BITS;
    localparam int MW = 2 * C + 2;

    // Front end to divider
    sgi_pkg::sgi_ctl_t    fe_ctl;
    logic                 fe_ready;
    logic [MW-1:0]        fe_d, fe_un;
    logic [C:0]           fe_mx, fe_my;
    logic signed [C-1:0]  fe_bx, fe_by;

    // Divider to output stage
    sgi_pkg::sgi_ctl_t    dv_ctl;
    logic                 dv_ready;
    logic [C:0]           dv_qx, dv_qy;
    logic signed [C-1:0]  dv_bx, dv_by;

    logic                 out_valid_reg, hit_reg;
    logic signed [C-1:0]  cross_x_reg, cross_y_reg;
    logic signed [C-1:0]  cross_x_next, cross_y_next;

    // Stage 1-4: differences, products, cross terms, sign fix and range test
    sgi_cross #(
        .C (C)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x1        (x1),
        .y1        (y1),
        .x2        (x2),
        .y2        (y2),
        .x3        (x3),
        .y3        (y3),
        .x4        (x4),
        .y4        (y4),
        .out_ctl   (fe_ctl),
        .out_ready (fe_ready),
        .d_abs     (fe_d),
        .un_abs    (fe_un),
        .mag_x     (fe_mx),
        .mag_y     (fe_my),
        .base_x    (fe_bx),
        .base_y    (fe_by)
    );

    // Stages 5 to C+5: bit-per-stage scaled quotient for both lanes
    sgi_div #(
        .C (C)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (fe_ctl),
        .in_ready   (fe_ready),
        .d_abs      (fe_d),
        .un_abs     (fe_un),
        .mag_x      (fe_mx),
        .mag_y      (fe_my),
        .base_x     (fe_bx),
        .base_y     (fe_by),
        .out_ctl    (dv_ctl),
        .out_ready  (dv_ready),
        .q_x        (dv_qx),
        .q_y        (dv_qy),
        .out_base_x (dv_bx),
        .out_base_y (dv_by)
    );

    // Output register: advance whenever it is empty or its transfer completes.
    assign dv_ready = !out_valid_reg || out_ready;

    // Apply the sign of the edge delta and add the start point; wrap to C bits; zero on a miss.
    // The quotient never exceeds the edge length, so no saturation is needed.
    always_comb
    begin
        cross_x_next = dv_bx + (dv_ctl.neg_x ? -C'(dv_qx) : C'(dv_qx));
        cross_y_next = dv_by + (dv_ctl.neg_y ? -C'(dv_qy) : C'(dv_qy));
        if (!dv_ctl.hit)
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dv_ready)
            out_valid_reg <= dv_ctl.valid;
    end

    // Hold the result while the downstream side stalls.
    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            hit_reg     <= dv_ctl.hit;
            cross_x_reg <= cross_x_next;
            cross_y_reg <= cross_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

endmodule

[hdl/sgi_cross.sv]
// Front end: edge vectors, cross products, sign normalization and hit test.
// Four register stages with elastic valid handshake. Depends on sgi_pkg.
module sgi_cross #(
    parameter int C = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [C-1:0]   x1,
    input  logic signed [C-1:0]   y1,
    input  logic signed [C-1:0]   x2,
    input  logic signed [C-1:0]   y2,
    input  logic signed [C-1:0]   x3,
    input  logic signed [C-1:0]   y3,
    input  logic signed [C-1:0]   x4,
    input  logic signed [C-1:0]   y4,
    output sgi_pkg::sgi_ctl_t     out_ctl,
    input  logic                  out_ready,
    output logic [2*C+1:0]        d_abs,
    output logic [2*C+1:0]        un_abs,
    output logic [C:0]            mag_x,
    output logic [C:0]            mag_y,
    output logic signed [C-1:0]   base_x,
    output logic signed [C-1:0]   base_y
);

    localparam int DW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int WW = 2 * C + 3;
    localparam int MW = 2 * C + 2;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3, en4;

    // stage 1: differences
    logic signed [DW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [C-1:0]  bx_1_reg, by_1_reg;
    // stage 2: products
    logic signed [PW-1:0] pab_reg, payx_reg, pcb_reg, pcyx_reg, pca_reg, pcya_reg;
    logic signed [DW-1:0] ax2_reg, ay2_reg;
    logic signed [C-1:0]  bx_2_reg, by_2_reg;
    // stage 3: denominators and numerators
    logic signed [WW-1:0] d3_reg, un3_reg, vn3_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg;
    logic signed [C-1:0]  bx_3_reg, by_3_reg;
    // stage 4 next values
    logic signed [WW-1:0] d_next, un_next, vn_next;
    logic                 hit_next;
    sgi_pkg::sgi_ctl_t    ctl_reg;

    assign en4      = !ctl_reg.valid || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign out_ctl  = ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
            begin
                ctl_reg.valid <= v3_reg;
                ctl_reg.hit   <= hit_next;
                ctl_reg.neg_x <= ax3_reg[DW-1];
                ctl_reg.neg_y <= ay3_reg[DW-1];
            end
        end
    end

    // Flip all three signs together so that the denominator is non-negative, then test for a hit.
    always_comb
    begin
        d_next   = d3_reg[WW-1] ? -d3_reg  : d3_reg;
        un_next  = d3_reg[WW-1] ? -un3_reg : un3_reg;
        vn_next  = d3_reg[WW-1] ? -vn3_reg : vn3_reg;
        hit_next = (d3_reg != '0) && !un_next[WW-1] && !vn_next[WW-1]
                   && (un_next <= d_next) && (vn_next <= d_next);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax1_reg  <= {x2[C-1], x2} - {x1[C-1], x1};
            ay1_reg  <= {y2[C-1], y2} - {y1[C-1], y1};
            bx1_reg  <= {x4[C-1], x4} - {x3[C-1], x3};
            by1_reg  <= {y4[C-1], y4} - {y3[C-1], y3};
            cx1_reg  <= {x3[C-1], x3} - {x1[C-1], x1};
            cy1_reg  <= {y3[C-1], y3} - {y1[C-1], y1};
            bx_1_reg <= x1;
            by_1_reg <= y1;
        end
        if (en2)
        begin
            pab_reg  <= PW'(ax1_reg) * PW'(by1_reg);
            payx_reg <= PW'(ay1_reg) * PW'(bx1_reg);
            pcb_reg  <= PW'(cx1_reg) * PW'(by1_reg);
            pcyx_reg <= PW'(cy1_reg) * PW'(bx1_reg);
            pca_reg  <= PW'(cx1_reg) * PW'(ay1_reg);
            pcya_reg <= PW'(cy1_reg) * PW'(ax1_reg);
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bx_2_reg <= bx_1_reg;
            by_2_reg <= by_1_reg;
        end
        if (en3)
        begin
            d3_reg   <= WW'(pab_reg) - WW'(payx_reg);
            un3_reg  <= WW'(pcb_reg) - WW'(pcyx_reg);
            vn3_reg  <= WW'(pca_reg) - WW'(pcya_reg);
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bx_3_reg <= bx_2_reg;
            by_3_reg <= by_2_reg;
        end
        if (en4)
        begin
            d_abs  <= d_next[MW-1:0];
            un_abs <= un_next[MW-1:0];
            mag_x  <= ax3_reg[DW-1] ? DW'(-ax3_reg) : DW'(ax3_reg);
            mag_y  <= ay3_reg[DW-1] ? DW'(-ay3_reg) : DW'(ay3_reg);
            base_x <= bx_3_reg;
            base_y <= by_3_reg;
        end
    end

endmodule

[hdl/sgi_div.sv]
// Pipelined scaled quotient trunc(un * mag / d) for the x and y lanes.
// One register stage per bit of the magnitude. Depends on sgi_pkg.
module sgi_div #(
    parameter int C = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgi_pkg::sgi_ctl_t     in_ctl,
    output logic                  in_ready,
    input  logic [2*C+1:0]        d_abs,
    input  logic [2*C+1:0]        un_abs,
    input  logic [C:0]            mag_x,
    input  logic [C:0]            mag_y,
    input  logic signed [C-1:0]   base_x,
    input  logic signed [C-1:0]   base_y,
    output sgi_pkg::sgi_ctl_t     out_ctl,
    input  logic                  out_ready,
    output logic [C:0]            q_x,
    output logic [C:0]            q_y,
    output logic signed [C-1:0]   out_base_x,
    output logic signed [C-1:0]   out_base_y
);

    localparam int DW = C + 1;
    localparam int MW = 2 * C + 2;
    localparam int AW = MW + 1;
    localparam int NS = C + 1;

    // One restoring step: shift in a multiple of un, remove up to two d.
    // Returns {count of d removed, new remainder}.
    function automatic logic [MW+1:0] div_step(
        input logic [MW-1:0] acc,
        input logic [MW-1:0] un,
        input logic [MW-1:0] d,
        input logic          add_un
    );
        logic [AW-1:0] t;
        logic [AW-1:0] s1;
        logic [AW-1:0] s2;
        logic [AW-1:0] d1;
        logic [AW-1:0] d2;
        t  = {acc, 1'b0} + (add_un ? {1'b0, un} : '0);
        d1 = {1'b0, d};
        d2 = {d, 1'b0};
        s1 = t - d1;
        s2 = t - d2;
        if (t >= d2)
            return {2'd2, s2[MW-1:0]};
        else if (t >= d1)
            return {2'd1, s1[MW-1:0]};
        else
            return {2'd0, t[MW-1:0]};
    endfunction

    sgi_pkg::sgi_ctl_t    ctl_stg [0:NS];
    logic [MW-1:0]        d_stg   [0:NS];
    logic [MW-1:0]        un_stg  [0:NS];
    logic [DW-1:0]        mx_stg  [0:NS];
    logic [DW-1:0]        my_stg  [0:NS];
    logic [MW-1:0]        ax_stg  [0:NS];
    logic [MW-1:0]        ay_stg  [0:NS];
    logic [DW-1:0]        qx_stg  [0:NS];
    logic [DW-1:0]        qy_stg  [0:NS];
    logic signed [C-1:0]  bx_stg  [0:NS];
    logic signed [C-1:0]  by_stg  [0:NS];
    logic                 en      [1:NS+1];

    assign ctl_stg[0] = in_ctl;
    assign d_stg[0]   = d_abs;
    assign un_stg[0]  = un_abs;
    assign mx_stg[0]  = mag_x;
    assign my_stg[0]  = mag_y;
    assign ax_stg[0]  = '0;
    assign ay_stg[0]  = '0;
    assign qx_stg[0]  = '0;
    assign qy_stg[0]  = '0;
    assign bx_stg[0]  = base_x;
    assign by_stg[0]  = base_y;

    assign en[NS+1]   = out_ready;
    assign in_ready   = en[1];

    assign out_ctl    = ctl_stg[NS];
    assign q_x        = qx_stg[NS];
    assign q_y        = qy_stg[NS];
    assign out_base_x = bx_stg[NS];
    assign out_base_y = by_stg[NS];

    for (genvar j = 1; j <= NS; j++)
    begin : g_stage
        sgi_pkg::sgi_ctl_t    ctl_reg;
        logic [MW-1:0]        d_reg, un_reg, ax_reg, ay_reg;
        logic [DW-1:0]        mx_reg, my_reg, qx_reg, qy_reg;
        logic signed [C-1:0]  bx_reg, by_reg;
        logic [MW+1:0]        sx_next, sy_next;

        assign en[j] = !ctl_reg.valid || en[j+1];

        // Bits of the magnitude are consumed from the top down.
        always_comb
        begin
            sx_next = div_step(ax_stg[j-1], un_stg[j-1], d_stg[j-1], mx_stg[j-1][NS-j]);
            sy_next = div_step(ay_stg[j-1], un_stg[j-1], d_stg[j-1], my_stg[j-1][NS-j]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg <= '0;
            else if (en[j])
                ctl_reg <= ctl_stg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                d_reg  <= d_stg[j-1];
                un_reg <= un_stg[j-1];
                mx_reg <= mx_stg[j-1];
                my_reg <= my_stg[j-1];
                ax_reg <= sx_next[MW-1:0];
                ay_reg <= sy_next[MW-1:0];
                qx_reg <= {qx_stg[j-1][DW-2:0], 1'b0} + DW'(sx_next[MW+1:MW]);
                qy_reg <= {qy_stg[j-1][DW-2:0], 1'b0} + DW'(sy_next[MW+1:MW]);
                bx_reg <= bx_stg[j-1];
                by_reg <= by_stg[j-1];
            end
        end

        assign ctl_stg[j] = ctl_reg;
        assign d_stg[j]   = d_reg;
        assign un_stg[j]  = un_reg;
        assign mx_stg[j]  = mx_reg;
        assign my_stg[j]  = my_reg;
        assign ax_stg[j]  = ax_reg;
        assign ay_stg[j]  = ay_reg;
        assign qx_stg[j]  = qx_reg;
        assign qy_stg[j]  = qy_reg;
        assign bx_stg[j]  = bx_reg;
        assign by_stg[j]  = by_reg;
    end

endmodule
